@@ hdl/mtet_pkg.sv @@
// Package for the modular tetration block: widths, limits and controller commands.
// Used by mtet_ctrl, mtet_dp and modular_tetration. No dependencies.
package mtet_pkg;

  localparam int W         = 64;
  localparam int DEPTH_W   = 4;
  localparam int MAX_DEPTH = 15;
  localparam int BIT_W     = 6;

  localparam logic CFG_DEPTH   = 1'b0;
  localparam logic CFG_MODULUS = 1'b1;

  // datapath command
  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,     // latch seed at the accepting edge, run = seed, clear reduction
    DP_RED_STEP, // one bit of seed mod m (restoring)
    DP_POW_INIT, // r = 1 mod m, p = seed mod m, e = run, run = seed mod m
    DP_MUL_INIT, // acc = 0, pick operands, bit = 63
    DP_MUL_STEP, // one shift-and-add step
    DP_MUL_DONE, // write product back
    DP_POW_END   // run = r
  } dp_cmd_e_t;

  typedef struct packed {
    dp_cmd_e_t cmd;
    logic      mul_sq;   // 1: p*p, 0: r*p
  } dp_ctl_t;

  typedef struct packed {
    logic bit_last;  // mul or reduction counter at 0
    logic e_zero;    // exponent exhausted
    logic e_lsb;     // current exponent bit
  } dp_sts_t;

endpackage

@@ hdl/mtet_dp.sv @@
// Datapath: seed reduction, square-and-multiply exponent, shift-and-add product.
// Depends on mtet_pkg; driven by mtet_ctrl.
module mtet_dp (
  input  logic                  clk,
  input  mtet_pkg::dp_ctl_t     ctl,
  input  logic [mtet_pkg::W-1:0] seed,
  input  logic [mtet_pkg::W-1:0] modulus,
  output mtet_pkg::dp_sts_t     sts,
  output logic [mtet_pkg::W-1:0] run
);

  logic [mtet_pkg::W-1:0]     seed_r, run_r, red_r, r_r, p_r, e_r, acc_r, a_r, b_r;
  logic [mtet_pkg::BIT_W-1:0] bit_r;
  logic                       sq_r;
  logic [mtet_pkg::W-1:0]     dbl, acc2, gap, red_nxt;
  logic [mtet_pkg::W:0]       red_sh;

  // acc doubled mod m, then optional add of a
  always_comb begin
    gap  = modulus - acc_r;
    dbl  = (acc_r >= gap) ? acc_r - gap : acc_r + acc_r;
    gap  = modulus - a_r;
    acc2 = b_r[bit_r] ? ((dbl >= gap) ? dbl - gap : dbl + a_r) : dbl;
  end

  // restoring remainder step
  always_comb begin
    red_sh  = {red_r, seed_r[bit_r]};
    red_nxt = (red_sh >= {1'b0, modulus}) ? mtet_pkg::W'(red_sh - {1'b0, modulus})
                                          : red_sh[mtet_pkg::W-1:0];
  end

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      mtet_pkg::DP_LOAD: begin
        seed_r <= seed;
        run_r  <= seed;
        red_r  <= '0;
        bit_r  <= mtet_pkg::BIT_W'(mtet_pkg::W - 1);
      end
      mtet_pkg::DP_RED_STEP: begin
        red_r <= red_nxt;
        bit_r <= bit_r - 1'b1;
      end
      mtet_pkg::DP_POW_INIT: begin
        r_r   <= (modulus == mtet_pkg::W'(1)) ? '0 : mtet_pkg::W'(1);
        p_r   <= red_r;
        e_r   <= run_r;
        // depth 1 ends here with the reduced seed; later rounds overwrite run
        run_r <= red_r;
      end
      mtet_pkg::DP_MUL_INIT: begin
        acc_r <= '0;
        sq_r  <= ctl.mul_sq;
        a_r   <= ctl.mul_sq ? p_r : r_r;
        b_r   <= p_r;
        bit_r <= mtet_pkg::BIT_W'(mtet_pkg::W - 1);
      end
      mtet_pkg::DP_MUL_STEP: begin
        acc_r <= acc2;
        bit_r <= bit_r - 1'b1;
      end
      mtet_pkg::DP_MUL_DONE: begin
        if (sq_r) begin
          p_r <= acc_r;
          e_r <= e_r >> 1;
        end else begin
          r_r <= acc_r;
        end
      end
      mtet_pkg::DP_POW_END: run_r <= r_r;
      default: ;
    endcase
  end

  assign sts.bit_last = (bit_r == '0);
  assign sts.e_zero   = (e_r == '0);
  assign sts.e_lsb    = e_r[0];
  assign run          = run_r;

endmodule

@@ hdl/mtet_ctrl.sv @@
// Controller: sequences seed reduction, tower rounds and product steps.
// Depends on mtet_pkg; commands mtet_dp.
module mtet_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        bad,
  input  logic [mtet_pkg::DEPTH_W-1:0] depth,
  input  mtet_pkg::dp_sts_t           sts,
  output mtet_pkg::dp_ctl_t           ctl,
  output logic                        busy,
  output logic                        done,
  output logic                        err
);

  typedef enum logic [3:0] {
    S_IDLE, S_RED, S_PINIT, S_CHK, S_MINIT, S_MSTEP, S_MDONE, S_PEND, S_OUT
  } state_t;

  state_t                      state_r;
  logic [mtet_pkg::DEPTH_W-1:0] rounds_r;
  logic                        sq_r, err_r;

  // seed is latched at the accepting edge
  always_comb begin
    ctl.mul_sq = sq_r;
    unique case (state_r)
      S_IDLE:  ctl.cmd = start ? mtet_pkg::DP_LOAD : mtet_pkg::DP_NOP;
      S_RED:   ctl.cmd = mtet_pkg::DP_RED_STEP;
      S_PINIT: ctl.cmd = mtet_pkg::DP_POW_INIT;
      S_MINIT: ctl.cmd = mtet_pkg::DP_MUL_INIT;
      S_MSTEP: ctl.cmd = mtet_pkg::DP_MUL_STEP;
      S_MDONE: ctl.cmd = mtet_pkg::DP_MUL_DONE;
      S_PEND:  ctl.cmd = mtet_pkg::DP_POW_END;
      default: ctl.cmd = mtet_pkg::DP_NOP;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_OUT);
  assign err  = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rounds_r <= '0;
      sq_r     <= 1'b0;
      err_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (start) begin
          err_r    <= bad;
          // depth 1 needs only the reduction; otherwise depth-1 rounds
          rounds_r <= depth - 1'b1;
          state_r  <= bad ? S_OUT : S_RED;
        end
        S_RED:  if (sts.bit_last) state_r <= S_PINIT;
        S_PINIT: state_r <= (rounds_r == '0) ? S_OUT : S_CHK;
        // exponent loop: multiply if bit set, then square
        S_CHK: begin
          if (sts.e_zero) begin
            state_r <= S_PEND;
          end else begin
            sq_r    <= !sts.e_lsb;
            state_r <= S_MINIT;
          end
        end
        S_MINIT: state_r <= S_MSTEP;
        S_MSTEP: if (sts.bit_last) state_r <= S_MDONE;
        S_MDONE: begin
          if (sq_r) begin
            state_r <= S_CHK;
          end else begin
            sq_r    <= 1'b1;
            state_r <= S_MINIT;
          end
        end
        S_PEND: begin
          rounds_r <= rounds_r - 1'b1;
          state_r  <= (rounds_r == 4'd1) ? S_OUT : S_PINIT;
        end
        S_OUT:   state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/modular_tetration.sv @@
// Modular tetration: seed^^depth mod modulus, iterated square-and-multiply.
// Run length is set by the 64-step seed reduction and, above depth 1, by depth-1
// tower rounds of square-and-multiply over the exponent bits, each product being a
// shift-and-add modular product. Error inputs give the result in the next cycle.
// One item at a time; a new seed is accepted only once the block is idle again after
// the result. Synchronous active-low reset: depth 3, modulus all ones, block idle.
module modular_tetration (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [mtet_pkg::W-1:0]         in_seed,
  output logic                          out_valid,
  output logic [mtet_pkg::W-1:0]         out_value,
  output logic                          out_error,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [mtet_pkg::W-1:0]         cfg_data
);

  logic [mtet_pkg::DEPTH_W-1:0] depth_r;
  logic [mtet_pkg::W-1:0]       modulus_r;
  mtet_pkg::dp_ctl_t            ctl;
  mtet_pkg::dp_sts_t            sts;
  logic [mtet_pkg::W-1:0]       run;
  logic                         done, err, bad;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r   <= mtet_pkg::DEPTH_W'(3);
      modulus_r <= '1;
    end else if (cfg_valid) begin
      if (cfg_index == mtet_pkg::CFG_DEPTH) depth_r <= cfg_data[mtet_pkg::DEPTH_W-1:0];
      else                                  modulus_r <= cfg_data;
    end
  end

  assign bad = (depth_r == '0) || (in_seed == '0) || (modulus_r == '0);

  mtet_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .bad(bad), .depth(depth_r),
    .sts(sts), .ctl(ctl), .busy(busy), .done(done), .err(err)
  );

  mtet_dp u_dp (
    .clk(clk), .ctl(ctl), .seed(in_seed), .modulus(modulus_r), .sts(sts), .run(run)
  );

  // run holds the tower value when done
  assign out_valid = done;
  assign out_error = err;
  assign out_value = err ? '0 : run;

endmodule

@@ tb/sv/tb_modular_tetration.sv @@
// Self-checking testbench for modular_tetration: directed table, then random phases.
// Needs mtet_pkg and the modular_tetration RTL; a built-in predictor or a typed table row gives every expected result.
`timescale 1ns / 1ps

module tb_modular_tetration;

  localparam int W         = mtet_pkg::W;
  localparam int DEPTH_W   = mtet_pkg::DEPTH_W;
  localparam int MAX_DEPTH = mtet_pkg::MAX_DEPTH;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  logic [W-1:0]  in_seed;
  logic          out_valid;
  logic [W-1:0]  out_value;
  logic          out_error;
  logic          cfg_valid;
  logic          cfg_ready;
  logic          cfg_index;
  logic [W-1:0]  cfg_data;

  // one row of the directed table
  typedef struct {
    bit                 wr_cfg;
    logic [W-1:0]       depth_word;
    logic [W-1:0]       mod_word;
    logic [W-1:0]       seed;
    bit                 typed;
    logic [W-1:0]       value;
    logic               error;
  } tower_row_t;

  typedef struct {
    logic [W-1:0] value;
    logic         error;
  } tower_res_t;

  // predictor copy of the configuration registers
  logic [DEPTH_W-1:0] depth_reg;
  logic [W-1:0]       mod_reg;

  tower_res_t  pending_towers[$];
  tower_res_t  override_q[$];
  int          mismatches;
  int          results_seen;
  int          seeds_sent;
  int          cfg_writes;

  modular_tetration uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_seed   (in_seed),
    .out_valid (out_valid),
    .out_value (out_value),
    .out_error (out_error),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // (a * b) mod m with a double-width product
  function automatic logic [W-1:0] mul_reduce(logic [W-1:0] a, logic [W-1:0] b,
                                               logic [W-1:0] m);
    logic [2*W-1:0] prod;
    prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};
    return W'(prod % {{W{1'b0}}, m});
  endfunction

  function automatic logic [W-1:0] pow_reduce(logic [W-1:0] b, logic [W-1:0] e,
                                               logic [W-1:0] m);
    logic [W-1:0] r;
    logic [W-1:0] p;
    r = 1 % m;
    p = b % m;
    while (e != 0) begin
      if (e[0]) r = mul_reduce(r, p, m);
      p = mul_reduce(p, p, m);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic tower_res_t predict_tower(logic [W-1:0] seed);
    tower_res_t   res;
    int           height;
    logic [W-1:0] run;
    height = depth_reg;
    if (height == 0 || seed == 0 || mod_reg == 0) begin
      res.value = '0;
      res.error = 1'b1;
      return res;
    end
    if (height > MAX_DEPTH) height = MAX_DEPTH;
    if (height == 1) begin
      run = seed % mod_reg;
    end else begin
      run = seed;
      for (int i = 1; i < height; i++) run = pow_reduce(seed, run, mod_reg);
    end
    res.value = run;
    res.error = 1'b0;
    return res;
  endfunction

  // mostly back-to-back, sometimes short gaps, rarely long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(200, 20);
  endfunction

  task automatic wait_drained();
    while (pending_towers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == mtet_pkg::CFG_DEPTH) depth_reg = data[DEPTH_W-1:0];
    else mod_reg = data;
    cfg_writes++;
    @(posedge clk);
  endtask

  // one seed transfer; start stays high when the next follows at once
  task automatic send_seed(logic [W-1:0] seed, bit typed, tower_res_t typed_res);
    tower_res_t pred;
    int         gap;
    start   <= 1'b1;
    in_seed <= seed;
    do @(posedge clk); while (busy);
    pred = predict_tower(seed);
    if (typed) begin
      if (pred.value !== typed_res.value || pred.error !== typed_res.error)
        $display("table row disagrees with predictor for seed %h", seed);
      pred = typed_res;
    end
    pending_towers.push_back(pred);
    seeds_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result checker; results cannot be held off
  always @(posedge clk) begin
    tower_res_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_towers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result value=%h error=%b", out_value, out_error);
      end else begin
        want = pending_towers.pop_front();
        if (out_value !== want.value || out_error !== want.error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp value=%h error=%b, got value=%h error=%b",
                     want.value, want.error, out_value, out_error);
        end
      end
    end
  end

  tower_row_t table_rows[] = '{
    // reset config: zero seed is an error
    '{0, 0, 0, 64'd0, 1, 64'd0, 1'b1},
    '{0, 0, 0, 64'd2, 0, 0, 0},
    // zero depth
    '{1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd5, 1, 64'd0, 1'b1},
    // zero modulus
    '{1, 64'd2, 64'd0, 64'd5, 1, 64'd0, 1'b1},
    // depth 1: max mod max
    '{1, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'd0, 1'b0},
    // modulus one: always zero, no error
    '{1, 64'd1, 64'd1, 64'd7, 1, 64'd0, 1'b0},
    '{1, 64'd2, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'd0, 1'b0},
    '{1, 64'd2, 64'd1000, 64'd3, 0, 0, 0},
    // seed one gives one
    '{1, 64'd2, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 1, 64'd1, 1'b0},
    // running value hits zero: 4^4 mod 4 = 0, then 4^0 = 1
    '{1, 64'd3, 64'd4, 64'd4, 1, 64'd1, 1'b0},
    // upper bits of depth word ignored
    '{1, 64'hFFFF_FFFF_FFFF_FFF2, 64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0},
    '{1, 64'd2, 64'hFFFF_FFFF_FFFF_FFC5, 64'h8000_0000_0000_0000, 0, 0, 0},
    // tallest tower
    '{1, 64'd15, 64'd97, 64'd5, 0, 0, 0},
    '{1, 64'd15, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 0, 0, 0}
  };

  initial begin
    tower_res_t   typed_res;
    logic [W-1:0] seed;
    logic [W-1:0] mod_word;
    int           depth_pick;
    int           roll;
    mismatches   = 0;
    results_seen = 0;
    seeds_sent   = 0;
    cfg_writes   = 0;
    depth_reg    = 4'd3;
    mod_reg      = '1;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_seed   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= mtet_pkg::CFG_DEPTH;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (table_rows[i]) begin
      if (table_rows[i].wr_cfg) begin
        start <= 1'b0;
        wait_drained();
        write_reg(mtet_pkg::CFG_DEPTH, table_rows[i].depth_word);
        write_reg(mtet_pkg::CFG_MODULUS, table_rows[i].mod_word);
      end
      typed_res.value = table_rows[i].value;
      typed_res.error = table_rows[i].error;
      send_seed(table_rows[i].seed, table_rows[i].typed, typed_res);
    end

    // random phases; each starts from an idle block
    for (int ph = 0; ph < 7; ph++) begin
      start <= 1'b0;
      wait_drained();
      roll = $urandom_range(99);
      if (roll < 10)      mod_word = '0;
      else if (roll < 18) mod_word = 64'd1;
      else if (roll < 30) mod_word = '1;
      else if (roll < 60) mod_word = {48'd0, 16'($urandom)};
      else                mod_word = {$urandom, $urandom};
      roll = $urandom_range(99);
      if (roll < 8)       depth_pick = 0;
      else if (roll < 40) depth_pick = 1;
      else if (roll < 80) depth_pick = 2;
      else if (roll < 92) depth_pick = 3;
      else                depth_pick = $urandom_range(15, 4);
      // tall towers only with a short modulus, to bound the run length
      if (depth_pick > 3) mod_word = {48'd0, 16'($urandom)};
      write_reg(mtet_pkg::CFG_DEPTH, {$urandom, 28'($urandom), 4'(depth_pick)});
      write_reg(mtet_pkg::CFG_MODULUS, mod_word);
      for (int k = 0; k < 14; k++) begin
        roll = $urandom_range(99);
        if (roll < 5)       seed = '0;
        else if (roll < 9)  seed = 64'd1;
        else if (roll < 13) seed = '1;
        else                seed = {$urandom, $urandom};
        send_seed(seed, 0, typed_res);
      end
    end
    start <= 1'b0;

    while (pending_towers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d seeds, checked %0d results, %0d register writes, %0d mismatches",
             seeds_sent, results_seen, cfg_writes, mismatches);
    if (mismatches == 0 && pending_towers.size() == 0) begin
      $display("[modular_tetration] OK");
    end else begin
      $display("[modular_tetration] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(64'd400_000_000);
    $display("timeout with %0d results outstanding", pending_towers.size());
    $display("[modular_tetration] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/mtet_pkg.sv
hdl/mtet_dp.sv
hdl/mtet_ctrl.sv
hdl/modular_tetration.sv
tb/sv/tb_modular_tetration.sv
